// ===== src/ibvc_pkg.sv =====
// Shared types and constants for the ID-buffer visibility collector.
// Depends on nothing; every other file of the block imports it.
package ibvc_pkg;

	localparam int MAX_OBJECTS_DEF = 1024;
	localparam int VIEWS_DEF       = 6;
	localparam int OFFSETS_DEF     = 6;
	localparam int MAX_OUT_WORDS   = 16;
	localparam int PIX_W           = 16;
	localparam int CNT_W           = 11;
	localparam int DIV_STEPS       = PIX_W;
	localparam int REG_IDX_W       = 3;
	localparam int REG_DATA_W      = 16;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ID_STEP      = 3'd0,
		REG_OBJECT_COUNT = 3'd1,
		REG_FULL_VOLUME  = 3'd2,
		REG_LAYER_COUNT  = 3'd3,
		REG_GRID_WIDTH   = 3'd4,
		REG_GRID_DEPTH   = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_MARK,
		ST_COUNT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_low;
		logic [PIX_W-1:0] pixel_high;
		logic             end_of_view;
	} item_t;

	typedef struct packed {
		logic [63:0] mask_word;
		logic [3:0]  word_index;
		logic [15:0] slot_x;
		logic [15:0] slot_z;
		logic [7:0]  slot_layer;
		logic [10:0] visible_total;
		logic        last_word;
		logic        all_done;
	} result_t;

	// one lane's finding for one pixel
	typedef struct packed {
		logic             hit;
		logic [CNT_W-1:0] idx;
	} mark_t;

endpackage

// ===== src/ibvc_div_lane.sv =====
// One divider lane: restoring division of a pixel by id_step, one quotient
// bit per cycle, then the range check that turns the quotient into a mark.
// Depends on ibvc_pkg.
module ibvc_div_lane (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  logic                       step,
	input  logic [ibvc_pkg::PIX_W-1:0] pixel,
	input  logic [ibvc_pkg::PIX_W-1:0] divisor,
	input  logic [ibvc_pkg::CNT_W-1:0] count,
	output ibvc_pkg::mark_t            mark
);
	import ibvc_pkg::*;

	logic [PIX_W-1:0] rem_q;
	logic [PIX_W-1:0] quo_q;
	logic [PIX_W:0]   trial;
	logic             fits;
	logic [PIX_W-1:0] idx_full;

	assign trial = {rem_q, quo_q[PIX_W-1]};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			quo_q <= '0;
		end else if (load) begin
			rem_q <= '0;
			quo_q <= pixel;
		end else if (step) begin
			rem_q <= fits ? PIX_W'(trial - {1'b0, divisor}) : trial[PIX_W-1:0];
			quo_q <= {quo_q[PIX_W-2:0], fits};
		end
	end

	// index = quotient - 1, valid only below the object count
	assign idx_full = quo_q - PIX_W'(1);
	assign mark.hit = (divisor != '0) && (quo_q != '0)
		&& (idx_full < {{(PIX_W-CNT_W){1'b0}}, count});
	assign mark.idx = idx_full[CNT_W-1:0];

endmodule

// ===== src/ibvc_bitmap.sv =====
// Visibility bitmap: one flop per object bit, set by both lanes at once,
// read one 64-bit word at a time, cleared all together at slot end.
// Depends on ibvc_pkg.
module ibvc_bitmap #(
	parameter int WORDS = ibvc_pkg::MAX_OUT_WORDS,
	localparam int IDX_W = (WORDS > 1) ? $clog2(WORDS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             set_en,
	input  ibvc_pkg::mark_t  mark_a,
	input  ibvc_pkg::mark_t  mark_b,
	input  logic             clear,
	input  logic [IDX_W-1:0] rd_index,
	output logic [63:0]      rd_word
);
	import ibvc_pkg::*;

	localparam int WSEL_W = CNT_W - 6;

	logic [63:0]       map_q [WORDS];
	logic [WSEL_W-1:0] word_a;
	logic [WSEL_W-1:0] word_b;
	logic              store_a;
	logic              store_b;
	logic [63:0]       bit_a;
	logic [63:0]       bit_b;

	assign word_a  = mark_a.idx[CNT_W-1:6];
	assign word_b  = mark_b.idx[CNT_W-1:6];
	// drop marks that land beyond the words ever emitted
	assign store_a = set_en && mark_a.hit && (int'(word_a) < WORDS);
	assign store_b = set_en && mark_b.hit && (int'(word_b) < WORDS);
	assign bit_a   = 64'd1 << mark_a.idx[5:0];
	assign bit_b   = 64'd1 << mark_b.idx[5:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < WORDS; w++) map_q[w] <= '0;
		end else if (clear) begin
			for (int w = 0; w < WORDS; w++) map_q[w] <= '0;
		end else begin
			// merge both lanes into each word before the single update
			for (int w = 0; w < WORDS; w++) begin
				map_q[w] <= map_q[w]
					| ((store_a && int'(word_a) == w) ? bit_a : 64'd0)
					| ((store_b && int'(word_b) == w) ? bit_b : 64'd0);
			end
		end
	end

	assign rd_word = map_q[rd_index];

endmodule

// ===== src/id_buffer_visibility_collector_top.sv =====
// Top level of the ID-buffer visibility collector: configuration registers,
// control sequencer, two divider lanes, bitmap, slot counters and result word.
// Depends on ibvc_pkg, ibvc_div_lane and ibvc_bitmap.
//
// A word is taken when start is high and busy is low; busy then stays high
// while the two lanes divide their pixels by id_step in parallel, one quotient
// bit per cycle, and while the bitmap bits are set. On the word that completes
// a slot, the block then counts the visible bits of W bitmap words, one word
// per cycle, and sends them, where W is ceil(object_count/64) with the count
// clamped to MAX_OBJECTS, at least one and at most MAX_OUT_WORDS. Results
// leave one per cycle, each marked by result_strobe; the receiver cannot stall
// them. After the last slot of the grid, words are still taken but ignored
// until reset. Register writes take effect at once and belong between words.
module id_buffer_visibility_collector_top #(
	parameter int MAX_OBJECTS      = ibvc_pkg::MAX_OBJECTS_DEF,
	parameter int VIEWS_PER_SLOT   = ibvc_pkg::VIEWS_DEF,
	parameter int OFFSETS_PER_SLOT = ibvc_pkg::OFFSETS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  ibvc_pkg::item_t                 item,
	output logic                            busy,
	input  logic                            wr_en,
	input  logic [ibvc_pkg::REG_IDX_W-1:0]  wr_index,
	input  logic [ibvc_pkg::REG_DATA_W-1:0] wr_data,
	output logic                            result_strobe,
	output ibvc_pkg::result_t               result
);
	import ibvc_pkg::*;

	localparam int MAP_WORDS = (MAX_OBJECTS + 63) / 64;
	localparam int OUT_WORDS = (MAP_WORDS > MAX_OUT_WORDS) ? MAX_OUT_WORDS : MAP_WORDS;
	localparam int IDX_W     = (OUT_WORDS > 1) ? $clog2(OUT_WORDS) : 1;

	// configuration
	logic [15:0]      id_step_q;
	logic [CNT_W-1:0] object_count_q;
	logic             full_volume_q;
	logic [7:0]       layer_count_q;
	logic [15:0]      grid_width_q;
	logic [15:0]      grid_depth_q;

	// control and slot state
	state_t           state_q, state_d;
	logic [3:0]       step_q;
	logic             eov_q;
	logic [2:0]       view_q;
	logic [2:0]       offset_q;
	logic [7:0]       layer_q;
	logic [15:0]      x_q;
	logic [15:0]      z_q;
	logic             done_q;
	logic [10:0]      total_q;
	logic [IDX_W-1:0] k_q;

	logic             accept;
	logic             go;
	logic [CNT_W-1:0] cnt;
	mark_t            mark_a, mark_b;
	logic [63:0]      rd_word;
	logic [63:0]      masked;
	logic [6:0]       ones;
	logic [5:0]       words_raw;
	logic [5:0]       words_m1;
	logic             last_k;
	logic [2:0]       view_inc, offset_inc;
	logic             view_roll, offset_roll, slot_end;
	logic [7:0]       layer_inc;
	logic [15:0]      x_inc, z_inc;
	logic             layer_wrap, x_wrap, z_wrap, last_slot;

	assign busy   = state_q != ST_IDLE;
	assign accept = start && !busy;
	assign go     = accept && !done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_step_q      <= 16'd1;
			object_count_q <= '0;
			full_volume_q  <= 1'b0;
			layer_count_q  <= 8'd1;
			grid_width_q   <= 16'd1;
			grid_depth_q   <= 16'd1;
		end else if (wr_en) begin
			case (wr_index)
				REG_ID_STEP:      id_step_q      <= wr_data;
				REG_OBJECT_COUNT: object_count_q <= wr_data[CNT_W-1:0];
				REG_FULL_VOLUME:  full_volume_q  <= wr_data[0];
				REG_LAYER_COUNT:  layer_count_q  <= wr_data[7:0];
				REG_GRID_WIDTH:   grid_width_q   <= wr_data;
				REG_GRID_DEPTH:   grid_depth_q   <= wr_data;
				default: ;
			endcase
		end
	end

	assign cnt = (int'(object_count_q) > MAX_OBJECTS) ? CNT_W'(MAX_OBJECTS)
		: object_count_q;

	ibvc_div_lane u_lane_lo (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (go),
		.step    (state_q == ST_DIVIDE),
		.pixel   (item.pixel_low),
		.divisor (id_step_q),
		.count   (cnt),
		.mark    (mark_a)
	);

	ibvc_div_lane u_lane_hi (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (go),
		.step    (state_q == ST_DIVIDE),
		.pixel   (item.pixel_high),
		.divisor (id_step_q),
		.count   (cnt),
		.mark    (mark_b)
	);

	ibvc_bitmap #(.WORDS(OUT_WORDS)) u_bitmap (
		.clk      (clk),
		.arst_n   (arst_n),
		.set_en   (state_q == ST_MARK),
		.mark_a   (mark_a),
		.mark_b   (mark_b),
		.clear    (state_q == ST_EMIT && last_k),
		.rd_index (k_q),
		.rd_word  (rd_word)
	);

	// bits at or above the object count read as zero
	always_comb begin
		if (5'(k_q) < cnt[CNT_W-1:6]) begin
			masked = rd_word;
		end else if (5'(k_q) == cnt[CNT_W-1:6]) begin
			masked = rd_word & ((64'd1 << cnt[5:0]) - 64'd1);
		end else begin
			masked = '0;
		end
	end

	always_comb begin
		ones = '0;
		for (int b = 0; b < 64; b++) ones = ones + 7'(masked[b]);
	end

	assign words_raw = {1'b0, cnt[CNT_W-1:6]} + 6'(cnt[5:0] != '0);
	assign words_m1  = (words_raw == '0) ? '0
		: (int'(words_raw) > OUT_WORDS) ? 6'(OUT_WORDS - 1) : words_raw - 6'd1;
	assign last_k    = 6'(k_q) == words_m1;

	// view and offset rounds
	assign view_inc    = view_q + 3'd1;
	assign view_roll   = (view_inc == '0) || (int'(view_inc) >= VIEWS_PER_SLOT);
	assign offset_inc  = offset_q + 3'd1;
	assign offset_roll = (offset_inc == '0) || (int'(offset_inc) >= OFFSETS_PER_SLOT);
	assign slot_end    = eov_q && view_roll && (!full_volume_q || offset_roll);

	// grid position after this slot
	assign layer_inc  = layer_q + 8'd1;
	assign layer_wrap = (layer_inc == '0) || (layer_inc >= layer_count_q);
	assign x_inc      = x_q + 16'd1;
	assign x_wrap     = (x_inc == '0) || (x_inc >= grid_width_q);
	assign z_inc      = z_q + 16'd1;
	assign z_wrap     = (z_inc == '0) || (z_inc >= grid_depth_q);
	assign last_slot  = layer_wrap && x_wrap && z_wrap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (go) state_d = ST_DIVIDE;
			ST_DIVIDE: if (step_q == 4'(DIV_STEPS - 1)) state_d = ST_MARK;
			ST_MARK:   state_d = slot_end ? ST_COUNT : ST_IDLE;
			ST_COUNT:  if (last_k) state_d = ST_EMIT;
			ST_EMIT:   if (last_k) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= '0;
			eov_q    <= 1'b0;
			view_q   <= '0;
			offset_q <= '0;
			layer_q  <= '0;
			x_q      <= '0;
			z_q      <= '0;
			done_q   <= 1'b0;
			total_q  <= '0;
			k_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (go) begin
						eov_q  <= item.end_of_view;
						step_q <= '0;
					end
				end
				ST_DIVIDE: begin
					step_q <= step_q + 4'd1;
				end
				ST_MARK: begin
					k_q <= '0;
					if (eov_q) begin
						view_q <= view_roll ? 3'd0 : view_inc;
						if (view_roll && full_volume_q)
							offset_q <= offset_roll ? 3'd0 : offset_inc;
					end
					if (slot_end) total_q <= '0;
				end
				ST_COUNT: begin
					total_q <= total_q + 11'(ones);
					k_q     <= last_k ? '0 : k_q + IDX_W'(1);
				end
				ST_EMIT: begin
					k_q <= last_k ? '0 : k_q + IDX_W'(1);
					// advance layer, then x, then z once the last word is out
					if (last_k) begin
						layer_q <= layer_wrap ? 8'd0 : layer_inc;
						if (layer_wrap) begin
							x_q <= x_wrap ? 16'd0 : x_inc;
							if (x_wrap) begin
								z_q <= z_inc;
								if (z_wrap) done_q <= 1'b1;
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_strobe <= 1'b0;
		else         result_strobe <= state_q == ST_EMIT;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT) begin
			result.mask_word     <= masked;
			result.word_index    <= 4'(k_q);
			result.slot_x        <= x_q;
			result.slot_z        <= z_q;
			result.slot_layer    <= layer_q;
			result.visible_total <= total_q;
			result.last_word     <= last_k;
			result.all_done      <= last_slot;
		end
	end

`ifndef SYNTH
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy)
		else $error("block busy after grid finished");

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.last_word |=> !result_strobe)
		else $error("word sent after last word of slot");

	a_word_seq: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !result.last_word |=>
			result_strobe && result.word_index == $past(result.word_index) + 4'd1)
		else $error("slot words not contiguous");

	a_count_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COUNT |=> state_q == ST_COUNT || state_q == ST_EMIT)
		else $error("count phase left without emitting");
`endif

endmodule

// ===== tb/tb_id_buffer_visibility_collector_top.sv =====
// Self-checking testbench for id_buffer_visibility_collector_top: drives ID words
// and register writes from a job queue and checks every mask word against an
// in-bench visibility predictor. Depends on ibvc_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_id_buffer_visibility_collector_top;
	import ibvc_pkg::*;

	localparam int SETTLE_CYCLES = 64;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int PRINT_CAP     = 200;

	typedef enum logic [1:0] {
		JOB_WORD,
		JOB_REG,
		JOB_QUIESCE
	} job_kind_t;

	typedef struct {
		job_kind_t   kind;
		item_t       word;
		reg_idx_t    reg_sel;
		logic [15:0] reg_val;
	} job_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	item_t                 id_word = '0;
	logic                  busy;
	logic                  wr_en = 1'b0;
	logic [REG_IDX_W-1:0]  wr_index = '0;
	logic [REG_DATA_W-1:0] wr_data = '0;
	logic                  result_strobe;
	result_t               mask_out;

	job_t    job_q[$];
	result_t words_due[$];
	int      mismatch_count = 0;
	int      quiet_cycles = 0;
	int      cycle_count = 0;
	int      gap_left = 0;
	int      calm_left = 0;
	int      gen_step = 1;
	int      gen_count = 0;

	// predictor copy of the registers and the slot state
	logic [15:0] step_reg   = 16'd1;
	logic [10:0] count_reg  = '0;
	logic        full_reg   = 1'b0;
	logic [7:0]  layers_reg = 8'd1;
	logic [15:0] width_reg  = 16'd1;
	logic [15:0] depth_reg  = 16'd1;
	logic [63:0] seen_bits [16] = '{default: '0};
	logic [2:0]  view_ct   = '0;
	logic [2:0]  offset_ct = '0;
	logic [7:0]  layer_at  = '0;
	logic [15:0] x_at      = '0;
	logic [15:0] z_at      = '0;
	logic        grid_done = 1'b0;

	id_buffer_visibility_collector_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.item          (id_word),
		.busy          (busy),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.result_strobe (result_strobe),
		.result        (mask_out)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int live_count();
		return (count_reg > MAX_OBJECTS_DEF) ? MAX_OBJECTS_DEF : int'(count_reg);
	endfunction

	task automatic mark_object(input logic [15:0] pix);
		int quot;
		int idx;
		if (step_reg == 16'd0)
			return;
		quot = int'(pix / step_reg);
		if (quot == 0)
			return;
		idx = quot - 1;
		if (idx >= live_count())
			return;
		seen_bits[idx >> 6][idx & 63] = 1'b1;
	endtask

	// Apply one accepted ID word; queue the mask words of a finished slot.
	task automatic fold_id_word(input item_t w);
		int          cnt;
		int          words;
		int          base;
		int          total;
		logic [63:0] masked [16];
		logic [15:0] sx;
		logic [15:0] sz;
		logic [7:0]  sl;
		logic        last_slot;
		result_t     r;
		if (grid_done)
			return;
		mark_object(w.pixel_low);
		mark_object(w.pixel_high);
		if (!w.end_of_view)
			return;
		view_ct = view_ct + 3'd1;
		if (view_ct != 3'd0 && view_ct < VIEWS_DEF)
			return;
		view_ct = '0;
		if (full_reg) begin
			offset_ct = offset_ct + 3'd1;
			if (offset_ct != 3'd0 && offset_ct < OFFSETS_DEF)
				return;
			offset_ct = '0;
		end

		cnt = live_count();
		words = (cnt + 63) / 64;
		if (words == 0)
			words = 1;
		if (words > MAX_OUT_WORDS)
			words = MAX_OUT_WORDS;
		total = 0;
		for (int k = 0; k < words; k++) begin
			base = k * 64;
			masked[k] = seen_bits[k];
			// hide bits at or above the object count
			if (cnt <= base)
				masked[k] = '0;
			else if (cnt - base < 64)
				masked[k] &= (64'd1 << (cnt - base)) - 64'd1;
			total += $countones(masked[k]);
		end
		sx = x_at;
		sz = z_at;
		sl = layer_at;
		last_slot = 1'b0;
		foreach (seen_bits[i])
			seen_bits[i] = '0;

		// advance layer, then x, then z; a limit of zero wraps every time
		layer_at = layer_at + 8'd1;
		if (layer_at == 8'd0 || layer_at >= layers_reg) begin
			layer_at = '0;
			x_at = x_at + 16'd1;
			if (x_at == 16'd0 || x_at >= width_reg) begin
				x_at = '0;
				z_at = z_at + 16'd1;
				if (z_at == 16'd0 || z_at >= depth_reg) begin
					grid_done = 1'b1;
					last_slot = 1'b1;
				end
			end
		end

		for (int k = 0; k < words; k++) begin
			r.mask_word     = masked[k];
			r.word_index    = 4'(k);
			r.slot_x        = sx;
			r.slot_z        = sz;
			r.slot_layer    = sl;
			r.visible_total = 11'(total);
			r.last_word     = (k == words - 1);
			r.all_done      = last_slot;
			words_due = {words_due, r};
		end
	endtask

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		// cap the printout; the count keeps going
		if (mismatch_count <= PRINT_CAP)
			$display("MISMATCH @%0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	task automatic drop_missing();
		report_mismatch($sformatf("%0d mask words never arrived", words_due.size()));
		words_due.delete();
	endtask

	task automatic push_word(input logic [15:0] lo, input logic [15:0] hi, input logic eov);
		job_t j;
		j.kind    = JOB_WORD;
		j.word    = '{pixel_low: lo, pixel_high: hi, end_of_view: eov};
		j.reg_sel = REG_ID_STEP;
		j.reg_val = '0;
		job_q = {job_q, j};
	endtask

	task automatic push_reg(input reg_idx_t sel, input logic [15:0] val);
		job_t j;
		j.kind    = JOB_REG;
		j.word    = '0;
		j.reg_sel = sel;
		j.reg_val = val;
		job_q = {job_q, j};
	endtask

	task automatic push_quiesce();
		job_t j;
		j.kind    = JOB_QUIESCE;
		j.word    = '0;
		j.reg_sel = REG_ID_STEP;
		j.reg_val = '0;
		job_q = {job_q, j};
	endtask

	// Let the block go idle, then rewrite every register.
	task automatic add_phase(input logic [15:0] step, input logic [15:0] count,
			input logic full, input logic [7:0] layers, input logic [15:0] width,
			input logic [15:0] depth);
		push_quiesce();
		push_reg(REG_ID_STEP, step);
		push_reg(REG_OBJECT_COUNT, count);
		push_reg(REG_FULL_VOLUME, {15'd0, full});
		push_reg(REG_LAYER_COUNT, {8'd0, layers});
		push_reg(REG_GRID_WIDTH, width);
		push_reg(REG_GRID_DEPTH, depth);
		gen_step  = int'(step);
		gen_count = (count[10:0] > MAX_OBJECTS_DEF) ? MAX_OBJECTS_DEF : int'(count[10:0]);
	endtask

	// Mostly pixels that land near or inside the object range, some raw noise.
	function automatic logic [15:0] gen_pixel();
		int     r;
		int     idx;
		longint p;
		r = $urandom_range(0, 99);
		if (r < 15 || gen_step == 0)
			return 16'($urandom);
		if (r < 20)
			return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
		idx = $urandom_range(0, gen_count + 3);
		p = longint'(idx + 1) * gen_step + $urandom_range(0, gen_step - 1);
		return (p > 65535) ? 16'($urandom) : 16'(p);
	endfunction

	task automatic add_words(input int n, input int eov_pct);
		for (int i = 0; i < n; i++)
			push_word(gen_pixel(), gen_pixel(), $urandom_range(0, 99) < eov_pct);
	endtask

	// Driver: one job per cycle while start is low, the gap has run out and no quiesce job holds.
	always @(posedge clk or negedge arst_n) begin : drive
		job_t nxt;
		logic start_d;
		logic wr_en_d;
		int   r;
		if (!arst_n) begin
			start    <= 1'b0;
			id_word  <= '0;
			wr_en    <= 1'b0;
			wr_index <= '0;
			wr_data  <= '0;
		end else begin
			start_d = start;
			wr_en_d = 1'b0;
			if (start && !busy) begin
				fold_id_word(id_word);
				start_d = 1'b0;
				r = $urandom_range(0, 99);
				if (calm_left > 0) begin
					calm_left--;
					gap_left = 0;
				end else if (r < 4) begin
					calm_left = $urandom_range(15, 40);
					gap_left = 0;
				end else if (r < 45)
					gap_left = 0;
				else if (r < 88)
					gap_left = $urandom_range(1, 4);
				else
					gap_left = $urandom_range(8, 40);
			end
			if (!start_d) begin
				if (gap_left > 0)
					gap_left--;
				else if (job_q.size() != 0) begin
					nxt = job_q[0];
					case (nxt.kind)
						JOB_WORD: begin
							id_word <= nxt.word;
							start_d = 1'b1;
							job_q.delete(0);
						end
						JOB_REG: begin
							wr_en_d = 1'b1;
							wr_index <= nxt.reg_sel;
							wr_data  <= nxt.reg_val;
							case (nxt.reg_sel)
								REG_ID_STEP:      step_reg   = nxt.reg_val;
								REG_OBJECT_COUNT: count_reg  = nxt.reg_val[10:0];
								REG_FULL_VOLUME:  full_reg   = nxt.reg_val[0];
								REG_LAYER_COUNT:  layers_reg = nxt.reg_val[7:0];
								REG_GRID_WIDTH:   width_reg  = nxt.reg_val;
								REG_GRID_DEPTH:   depth_reg  = nxt.reg_val;
								default: ;
							endcase
							job_q.delete(0);
						end
						JOB_QUIESCE: begin
							// hold until the block has been silent long enough to be idle
							if (quiet_cycles >= SETTLE_CYCLES) begin
								if (words_due.size() != 0)
									drop_missing();
								job_q.delete(0);
							end
						end
						default: job_q.delete(0);
					endcase
				end
			end
			start <= start_d;
			wr_en <= wr_en_d;
		end
	end

	// Monitor: every strobe carries one mask word.
	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n)
			quiet_cycles <= 0;
		else begin
			if (result_strobe === 1'b1) begin
				quiet_cycles <= 0;
				if (words_due.size() == 0)
					report_mismatch($sformatf("unexpected mask word %h idx %0d",
						mask_out.mask_word, mask_out.word_index));
				else begin
					want = words_due.pop_front();
					check_field("mask_word", mask_out.mask_word, want.mask_word);
					check_field("word_index", mask_out.word_index, want.word_index);
					check_field("slot_x", mask_out.slot_x, want.slot_x);
					check_field("slot_z", mask_out.slot_z, want.slot_z);
					check_field("slot_layer", mask_out.slot_layer, want.slot_layer);
					check_field("visible_total", mask_out.visible_total, want.visible_total);
					check_field("last_word", mask_out.last_word, want.last_word);
					check_field("all_done", mask_out.all_done, want.all_done);
				end
			end else if (start && !busy)
				quiet_cycles <= 0;
			else if (quiet_cycles < SETTLE_CYCLES)
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		// directed: range edges, pixel zero, both pixels of one word, a full slot
		add_phase(16'd1, 16'd1024, 1'b0, 8'd3, 16'd2, 16'd65535);
		push_word(16'd0, 16'd1, 1'b0);
		push_word(16'd1024, 16'd1025, 1'b0);
		push_word(16'hffff, 16'd64, 1'b0);
		push_word(16'd65, 16'd128, 1'b1);
		push_word(16'd0, 16'd0, 1'b1);
		push_word(16'h5555, 16'haaaa, 1'b1);
		push_word(16'd2, 16'd2, 1'b1);
		push_word(16'd512, 16'd513, 1'b1);
		push_word(16'd1000, 16'd0, 1'b1);
		// zero step marks nothing; count above the maximum clamps to 16 words
		add_phase(16'd0, 16'hffff, 1'b0, 8'd3, 16'd2, 16'd65535);
		push_word(16'd1, 16'hffff, 1'b1);
		push_word(16'd2, 16'd3, 1'b1);
		push_word(16'h8000, 16'h7fff, 1'b1);
		push_word(16'd100, 16'd200, 1'b1);
		push_word(16'd0, 16'd1, 1'b1);
		push_word(16'd5, 16'd6, 1'b1);
		// zero count still sends one empty word
		add_phase(16'd3, 16'd0, 1'b0, 8'd3, 16'd2, 16'd65535);
		push_word(16'd3, 16'hffff, 1'b1);
		push_word(16'd6, 16'd9, 1'b1);
		push_word(16'd3, 16'd3, 1'b1);
		push_word(16'd0, 16'd12, 1'b1);
		push_word(16'd4, 16'd5, 1'b1);
		push_word(16'd7, 16'd8, 1'b1);

		add_phase(16'd1, 16'd64, 1'b0, 8'd255, 16'd65535, 16'd65535);
		add_words(30, 40);
		push_quiesce();
		add_words(30, 40);
		add_phase(16'd65535, 16'd1, 1'b1, 8'd255, 16'd65535, 16'd65535);
		add_words(50, 80);
		// layer limit drops below the current layer
		add_phase(16'($urandom_range(1, 20)), 16'($urandom_range(1, 1024)), 1'b0,
			8'd1, 16'd3, 16'd65535);
		add_words(50, 50);
		add_phase(16'd7, 16'd1000, 1'b1, 8'd2, 16'd65535, 16'd65535);
		add_words(50, 90);
		add_phase(16'($urandom_range(1, 64)), 16'd1024, 1'b0, 8'd0, 16'd0, 16'd65535);
		add_words(40, 50);
		// zero depth ends the grid after four slots; later words are ignored
		add_phase(16'd1, 16'd1024, 1'b0, 8'd2, 16'd2, 16'd0);
		add_words(50, 70);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		@(posedge clk);
		while (job_q.size() != 0 || start)
			@(posedge clk);
		while (quiet_cycles < SETTLE_CYCLES)
			@(posedge clk);
		if (words_due.size() != 0)
			drop_missing();
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
src/ibvc_pkg.sv
src/ibvc_div_lane.sv
src/ibvc_bitmap.sv
src/id_buffer_visibility_collector_top.sv
tb/tb_id_buffer_visibility_collector_top.sv
